// ===== rtl/plir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package plir_pkg;

  localparam int POS_W  = 7;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEL
  } state_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic              commit;
    req_kind_e         kind;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/plir_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface plir_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output position, output value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input value,
                  output ready);
endinterface

interface plir_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [7:0]         length_now;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, output status, output read_value, output length_now,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input read_value, input length_now,
                  input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ===== rtl/positional_insert_remove_list_top.sv =====
// A request is taken in the transfer, applied in the execute state, and its
// result is registered for output in the select state. A new request is taken
// only after the select state, which is set by the two-stage read select over the
// cell chain; the select state is held while the output register is stalled.
// Reset: rst_ni is asynchronous, active low; it clears the entry count and the
//   handshake control. Cell contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_remove_list_top #(
  parameter int CAPACITY = 128
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  plir_in_if.sink   in_i,
  plir_out_if.source out_o
);
  import plir_pkg::*;

  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int W        = (CW > POS_W) ? CW : POS_W;
  localparam int GrpSize  = 16;
  localparam int GrpW     = $clog2(GrpSize);
  localparam int NumGrp   = (CAPACITY + GrpSize - 1) / GrpSize;
  // Only positions that fit the position field can ever be read.
  localparam int MaxGrp   = (1 << POS_W) / GrpSize;
  localparam int ReachGrp = (NumGrp < MaxGrp) ? NumGrp : MaxGrp;

  state_e            state_q, state_d;
  req_kind_e         kind_q;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] word_q;
  logic [CW-1:0]     count_q, count_d;
  status_e           status_q, status_c;

  logic [WORD_W-1:0] cell_val [CAPACITY];
  logic [WORD_W-1:0] val_pad  [NumGrp*GrpSize];
  logic [WORD_W-1:0] grp_q    [ReachGrp];
  logic [WORD_W-1:0] grp_d    [ReachGrp];
  logic [WORD_W-1:0] rd_sel;

  cell_cmd_t cmd;
  logic      in_xfer, load_out, exec;
  logic      full_c, empty_c;
  logic [W-1:0] pos_w, count_w;
  logic [CW+7:0] count_ext;

  logic               out_valid_q, out_valid_d;
  status_e            out_status_q;
  logic [WORD_W-1:0]  out_rd_q;
  logic [7:0]         out_len_q;
  logic               out_empty_q, out_full_q;

  assign in_xfer = in_i.valid && in_i.ready;
  assign exec    = (state_q == S_EXEC);

  // Request checks against the count held before the request.
  assign pos_w   = W'(pos_q);
  assign count_w = W'(count_q);
  assign full_c  = (count_q == CW'(CAPACITY));
  assign empty_c = (count_q == '0);

  always_comb begin
    status_c = ST_OK;
    unique case (kind_q) inside
      REQ_APPEND: begin
        if (full_c) status_c = ST_FULL;
      end
      REQ_INSERT: begin
        if (full_c) status_c = ST_FULL;
        else if (pos_w > count_w) status_c = ST_BADPOS;
      end
      REQ_REMOVE, REQ_READ: begin
        if (empty_c) status_c = ST_EMPTY;
        else if (pos_w >= count_w) status_c = ST_BADPOS;
      end
      default: status_c = ST_OK;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (exec && (status_c == ST_OK)) begin
      case (kind_q) inside
        REQ_APPEND, REQ_INSERT: count_d = count_q + CW'(1);
        REQ_REMOVE:             count_d = count_q - CW'(1);
        default:                count_d = count_q;
      endcase
    end
  end

  // Broadcast a successful append, insert or remove to the whole chain for one cycle.
  assign cmd.commit = exec && (status_c == ST_OK) && (kind_q != REQ_READ);
  assign cmd.kind   = kind_q;
  assign cmd.pos    = pos_q;
  assign cmd.word   = word_q;

  // Chain of cells: each holds one entry and takes its neighbor's word on a shift.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_val[i+1];
    end
    plir_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count_q),
      .lower_i (lower),
      .upper_i (upper),
      .value_o (cell_val[i])
    );
  end

  for (genvar j = 0; j < NumGrp*GrpSize; j++) begin : g_pad
    if (j < CAPACITY) begin : g_used
      assign val_pad[j] = cell_val[j];
    end else begin : g_unused
      assign val_pad[j] = '0;
    end
  end

  // Read select, first stage: pick the entry named by the low position bits in every group.
  always_comb begin
    for (int g = 0; g < ReachGrp; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GrpSize; k++) begin
        if (pos_q[GrpW-1:0] == GrpW'(k)) grp_d[g] = val_pad[g*GrpSize + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      for (int g = 0; g < ReachGrp; g++) grp_q[g] <= grp_d[g];
    end
  end

  // Second stage: pick the group.
  always_comb begin
    rd_sel = '0;
    for (int g = 0; g < ReachGrp; g++) begin
      if (pos_q[POS_W-1:GrpW] == (POS_W-GrpW)'(g)) rd_sel = grp_q[g];
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_xfer) state_d = S_EXEC;
      S_EXEC: state_d = S_SEL;
      S_SEL:  if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_i.ready = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_EXEC:  in_i.ready = 1'b0;
      S_SEL:   load_out   = !out_valid_q || out_o.ready;
      default: in_i.ready = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the request and its status; no reset on payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= req_kind_e'(in_i.req_type);
      pos_q  <= in_i.position;
      word_q <= WORD_W'(in_i.value);
    end
    if (exec) status_q <= status_c;
  end

  assign count_ext = (CW+8)'(count_q);

  // Output register: count_q already holds the length after the request.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= status_q;
      out_rd_q     <= ((status_q == ST_OK) && (kind_q == REQ_READ)) ? rd_sel : '0;
      out_len_q    <= count_ext[7:0];
      out_empty_q  <= (count_q == '0);
      out_full_q   <= (count_q == CW'(CAPACITY));
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.read_value = out_rd_q;
  assign out_o.length_now = out_len_q;
  assign out_o.is_empty   = out_empty_q;
  assign out_o.is_full    = out_full_q;

endmodule

`default_nettype wire

// ===== rtl/plir_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module plir_cell #(
  parameter int CAPACITY = 128,
  parameter int IDX      = 0
) (
  input  wire logic                                 clk_i,
  input  wire plir_pkg::cell_cmd_t                  cmd_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]        count_i,
  input  wire logic [plir_pkg::WORD_W-1:0]          lower_i,
  input  wire logic [plir_pkg::WORD_W-1:0]          upper_i,
  output logic      [plir_pkg::WORD_W-1:0]          value_o
);
  import plir_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int W  = (CW > POS_W) ? CW : POS_W;
  localparam logic [W-1:0] IdxW = W'(IDX);

  logic [WORD_W-1:0] value_q, value_d;
  logic [W-1:0]      pos_w, count_w;

  assign pos_w   = W'(cmd_i.pos);
  assign count_w = W'(count_i);

  always_comb begin
    value_d = value_q;
    if (cmd_i.commit) begin
      case (cmd_i.kind)
        REQ_APPEND: begin
          if (IdxW == count_w) value_d = cmd_i.word;
        end
        REQ_INSERT: begin
          if (IdxW == pos_w) value_d = cmd_i.word;
          else if (IdxW > pos_w) value_d = lower_i;
        end
        REQ_REMOVE: begin
          if (IdxW >= pos_w) value_d = upper_i;
        end
        default: value_d = value_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== rtl/plir_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module plir_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_i,
  input wire logic [31:0] read_value_i,
  input wire logic [7:0]  length_now_i,
  input wire logic        is_empty_i,
  input wire logic        is_full_i
);
  import plir_pkg::*;

  // One request in flight: no second transfer right after one.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while a request is in flight");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i != ST_OK)) |-> (read_value_i == '0))
    else $error("nonzero read value on a failed request");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!(is_empty_i && is_full_i) && (!is_empty_i || length_now_i == '0)))
    else $error("empty or full flag disagrees with length");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(status_i)
                                       && $stable(read_value_i)))
    else $error("stalled result changed");

endmodule

bind positional_insert_remove_list_top plir_checker u_plir_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .read_value_i (out_o.read_value),
  .length_now_i (out_o.length_now),
  .is_empty_i   (out_o.is_empty),
  .is_full_i    (out_o.is_full)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import plir_pkg::*;

  localparam int          CAPACITY  = 128;
  localparam int unsigned MAX_POS   = (1 << POS_W) - 1;
  localparam int unsigned HOLD_OFF  = 300;   // long receiver stall, in cycles
  localparam int unsigned DRAIN_PAD = 10;    // cycles to watch for strays at the end
  localparam int unsigned RUN_LIMIT = 5_000_000;  // ns

  localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MARK = 32'd99;

  // One reply of the list, as the block reports it.
  typedef struct packed {
    status_e           status;
    logic [WORD_W-1:0] read_value;
    logic [7:0]        length_now;
    logic              is_empty;
    logic              is_full;
  } list_reply_t;

  // Ready patterns of the result receiver.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_e;

  logic clk_i;
  logic rst_ni;

  plir_in_if  req_bus ();
  plir_out_if rsp_bus ();

  positional_insert_remove_list_top #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_bus),
    .out_o (rsp_bus)
  );

  // Shadow copy of the list. Entries at or above shadow_len are never read.
  logic [WORD_W-1:0] shadow_words [CAPACITY];
  int unsigned       shadow_len;

  // Replies owed by the block, oldest first.
  list_reply_t replies_due [$];
  int unsigned error_count;

  // Sender burst control.
  int unsigned burst_left;
  bit          sender_steady;

  // Bump to make the receiver hold ready low for a stall of length HOLD_OFF.
  int unsigned hold_off_seq;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run; a correct run ends long before this.
  initial begin : run_limit
    #(RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction: apply one request to the shadow list and return its reply
  // ---------------------------------------------------------------------------
  function automatic list_reply_t apply_to_shadow_list(req_kind_e kind,
                                                       logic [POS_W-1:0] pos,
                                                       logic [WORD_W-1:0] word);
    list_reply_t reply;
    reply.status     = ST_OK;
    reply.read_value = '0;
    case (kind)
      REQ_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          shadow_words[shadow_len] = word;
          shadow_len++;
        end
      end
      REQ_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          reply.status = ST_FULL;
        end else if (pos > shadow_len) begin
          reply.status = ST_BADPOS;
        end else begin
          // Shift the tail up by one, then drop the word into the gap.
          for (int i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = word;
          shadow_len++;
        end
      end
      REQ_REMOVE: begin
        if (shadow_len == 0) begin
          reply.status = ST_EMPTY;
        end else if (pos >= shadow_len) begin
          reply.status = ST_BADPOS;
        end else begin
          // Close the gap by shifting the tail down by one.
          for (int i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      default: begin
        if (shadow_len == 0) begin
          reply.status = ST_EMPTY;
        end else if (pos >= shadow_len) begin
          reply.status = ST_BADPOS;
        end else begin
          reply.read_value = shadow_words[pos];
        end
      end
    endcase
    reply.length_now = 8'(shadow_len);
    reply.is_empty   = (shadow_len == 0);
    reply.is_full    = (shadow_len >= CAPACITY);
    return reply;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly a position that hits the list; now and then any position at all.
  function automatic logic [POS_W-1:0] pick_position(req_kind_e kind);
    int unsigned top;
    if (kind == REQ_INSERT) top = shadow_len;
    else top = (shadow_len == 0) ? 0 : shadow_len - 1;
    if (top > MAX_POS) top = MAX_POS;
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, MAX_POS));
    return POS_W'($urandom_range(0, top));
  endfunction

  // Random word, with the extremes and the marker values mixed in.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return WORD_ONES;
      3:       return WORD_MARK;
      4:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and hold it until the transfer; then predict its reply.
  // Valid stays high after the transfer so that bursts run back to back.
  task automatic send_request(req_kind_e kind, logic [POS_W-1:0] pos,
                              logic [WORD_W-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.position <= pos;
    req_bus.value    <= word;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    replies_due.push_back(apply_to_shadow_list(kind, pos, word));
  endtask

  // Random request: grow_pct percent append or insert, the rest remove or read.
  task automatic send_random_request(int unsigned grow_pct);
    req_kind_e kind;
    if ($urandom_range(0, 99) < grow_pct)
      kind = $urandom_range(0, 1) ? REQ_APPEND : REQ_INSERT;
    else
      kind = ($urandom_range(0, 2) != 0) ? REQ_REMOVE : REQ_READ;
    if (kind == REQ_APPEND) send_request(kind, POS_W'($urandom_range(0, MAX_POS)), pick_word());
    else send_request(kind, pick_position(kind), pick_word());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty list, edges of position and word, every request kind, empty and bad-position failures.
  task automatic test_edge_cases();
    send_request(REQ_READ,   '0, '0);                     // read when empty
    send_request(REQ_REMOVE, POS_W'(MAX_POS), WORD_ONES); // remove when empty
    send_request(REQ_INSERT, 7'd1, WORD_MAX);             // insert past the end
    send_request(REQ_INSERT, 7'd0, WORD_MIN);             // insert into empty list
    send_request(REQ_APPEND, POS_W'(MAX_POS), WORD_MAX);
    send_request(REQ_APPEND, 7'd0, WORD_ONES);
    send_request(REQ_INSERT, 7'd3, WORD_MARK);            // position equal to length
    send_request(REQ_INSERT, 7'd1, '0);                   // insert in the middle
    for (int p = 0; p < 5; p++) send_request(REQ_READ, POS_W'(p), WORD_ONES);
    send_request(REQ_READ,   7'd5, '0);                   // read at the length
    send_request(REQ_READ,   POS_W'(MAX_POS), '0);
    send_request(REQ_REMOVE, 7'd5, '0);                   // remove at the length
    send_request(REQ_INSERT, 7'd6, WORD_MARK);            // insert one past the length
    send_request(REQ_REMOVE, 7'd4, '0);                   // remove the last
    send_request(REQ_REMOVE, 7'd0, '0);                   // remove the first
    send_request(REQ_REMOVE, 7'd1, '0);                   // remove from the middle
    send_request(REQ_READ,   7'd0, '0);
    send_request(REQ_READ,   7'd1, '0);
    send_request(REQ_REMOVE, 7'd0, '0);
    send_request(REQ_REMOVE, 7'd0, '0);                   // back to empty
    send_request(REQ_REMOVE, 7'd0, '0);                   // remove when empty again
  endtask

  // Fill to capacity, probe the full list, then drain to empty.
  task automatic test_fill_and_drain();
    while (shadow_len < CAPACITY) begin
      if ($urandom_range(0, 1))
        send_request(REQ_APPEND, POS_W'($urandom_range(0, MAX_POS)), pick_word());
      else
        send_request(REQ_INSERT, pick_position(REQ_INSERT), pick_word());
    end
    send_request(REQ_APPEND, '0, WORD_MARK);               // append when full
    send_request(REQ_INSERT, '0, WORD_MARK);               // insert when full
    send_request(REQ_INSERT, POS_W'(MAX_POS), WORD_MARK);
    send_request(REQ_READ,   '0, '0);
    send_request(REQ_READ,   POS_W'(MAX_POS), '0);         // last entry of a full list
    send_request(REQ_REMOVE, POS_W'(MAX_POS), '0);
    send_request(REQ_INSERT, POS_W'(MAX_POS), WORD_MIN);   // refill at the very end
    send_request(REQ_READ,   POS_W'(MAX_POS), '0);
    while (shadow_len != 0) begin
      if ($urandom_range(0, 3) == 0) send_request(REQ_READ, pick_position(REQ_READ), pick_word());
      else send_request(REQ_REMOVE, pick_position(REQ_REMOVE), pick_word());
    end
    send_request(REQ_READ, POS_W'($urandom_range(0, MAX_POS)), '0);
  endtask

  // Hold the receiver off while the sender keeps offering, so the block
  // backs up and stalls its input.
  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_off_seq++;
    repeat (40) send_random_request(60);
    sender_steady = 1'b0;
  endtask

  // Long random run in phases that grow, shrink and hover around a level.
  task automatic test_random_mix();
    repeat (200) send_random_request(70);
    repeat (300) send_random_request(25);
    repeat (200) send_random_request(70);
    repeat (200) send_random_request(40);
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: changes its ready pattern now and then, and holds off
  // for a long stretch whenever hold_off_seq moves.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    rx_pattern_e pattern;
    int unsigned pattern_left;
    int unsigned period;
    int unsigned phase;
    int unsigned hold_left;
    int unsigned seen_seq;
    rsp_bus.ready = 1'b0;
    pattern_left  = 0;
    period        = 3;
    phase         = 0;
    hold_left     = 0;
    seen_seq      = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_seq != seen_seq) begin
        seen_seq  = hold_off_seq;
        hold_left = HOLD_OFF;
      end
      if (pattern_left == 0) begin
        pattern      = rx_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 200);
        period       = $urandom_range(2, 5);
      end
      pattern_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        case (pattern)
          RX_OPEN:   rsp_bus.ready <= 1'b1;
          RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          default:   rsp_bus.ready <= (phase % period == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking: match every result transfer against the oldest reply due
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : reply_checker
    list_reply_t want;
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected: status %0d, length %0d", $time,
                 rsp_bus.status, rsp_bus.length_now);
      end else begin
        want = replies_due.pop_front();
        check_field("status",     want.status,     rsp_bus.status);
        check_field("read_value", want.read_value, rsp_bus.read_value);
        check_field("length_now", want.length_now, rsp_bus.length_now);
        check_field("is_empty",   want.is_empty,   rsp_bus.is_empty);
        check_field("is_full",    want.is_full,    rsp_bus.is_full);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    error_count      = 0;
    shadow_len       = 0;
    burst_left       = 0;
    sender_steady    = 1'b0;
    hold_off_seq     = 0;
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_APPEND;
    req_bus.position = '0;
    req_bus.value    = '0;

    // Hold reset, then release on an edge.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    test_fill_and_drain();
    test_backpressure();
    test_random_mix();

    // Drop valid, wait for every reply owed, then watch for strays.
    req_bus.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);

    if (error_count == 0 && replies_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
